[design/wcm_pkg.sv]
// ----------------------------------------------------------------------------
// wcm_pkg: shared types and constants for the wall column texture mapper
// Field widths, stream payload layouts, controller/datapath command and
// status groups, and small helpers used by more than one module.
// ----------------------------------------------------------------------------
package wcm_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SCREEN_BITS = 12;

	localparam int SIDE_W   = 2;
	localparam int COORD_W  = 31;
	localparam int DIR_W    = 21;
	localparam int LH_W     = 16;
	localparam int TEXW_W   = 11;
	localparam int HLOG_W   = 4;
	localparam int HLOG_MAX = 10;
	localparam int COL_W    = 10;
	localparam int POS_W    = 48;
	localparam int FI_W     = 24;
	localparam int TEXEL_W  = 20;
	localparam int BASE_W   = LH_W + 1;

	// step numerator is 1 << (hlog + FRAC_BITS)
	localparam int DIV_W     = HLOG_MAX + FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam int IN_FIELDS_W  = SIDE_W + 3 * COORD_W + 2 * DIR_W + LH_W + 3 * SCREEN_BITS;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = FI_W + TEXEL_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic {
		CMD_SETUP = 1'b0,
		CMD_ROW   = 1'b1
	} cmd_code_t;

	typedef enum logic [SIDE_W-1:0] {
		SIDE_NORTH = 2'd0,
		SIDE_SOUTH = 2'd1,
		SIDE_WEST  = 2'd2,
		SIDE_EAST  = 2'd3
	} side_t;

	typedef enum logic [1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HLOG2  = 2'd1,
		REG_SCR_WIDTH  = 2'd2,
		REG_SCR_HEIGHT = 2'd3
	} reg_idx_t;

	// first field in the lowest bits
	typedef struct packed {
		logic [IN_TDATA_W-IN_FIELDS_W-1:0] pad;
		logic [SCREEN_BITS-1:0]            column;
		logic [SCREEN_BITS-1:0]            row_end;
		logic [SCREEN_BITS-1:0]            row_first;
		logic [LH_W-1:0]                   line_height;
		logic [DIR_W-1:0]                  ray_dir_y;
		logic [DIR_W-1:0]                  ray_dir_x;
		logic [COORD_W-1:0]                perp_dist;
		logic [COORD_W-1:0]                player_y;
		logic [COORD_W-1:0]                player_x;
		logic [SIDE_W-1:0]                 side;
	} in_data_t;

	typedef struct packed {
		logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
		logic [TEXEL_W-1:0]                  texel_offset;
		logic [FI_W-1:0]                     frame_index;
	} out_data_t;

	typedef struct packed {
		logic capture;   // latch setup fields, form wall product
		logic frac_en;   // wall fraction, start step divide
		logic col_en;    // texture column product
		logic pos_en;    // start position product, arm the column
		logic emit;      // produce one row request
	} wcm_cmd_t;

	typedef struct packed {
		logic active;
		logic out_free;
		logic div_busy;
	} wcm_status_t;

	function automatic logic [HLOG_W-1:0] clamp_hlog(input logic [HLOG_W-1:0] v);
		return (v > HLOG_W'(HLOG_MAX)) ? HLOG_W'(HLOG_MAX) : v;
	endfunction

endpackage

[design/wcm_div.sv]
// ----------------------------------------------------------------------------
// wcm_div: restoring divider for the texture step
// One quotient bit per cycle; the quotient has DIV_W bits.
// ----------------------------------------------------------------------------
module wcm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wcm_pkg::DIV_W-1:0]    numer,
	input  logic [wcm_pkg::LH_W-1:0]     denom,
	output logic                         busy,
	output logic [wcm_pkg::DIV_W-1:0]    quot
);
	import wcm_pkg::*;

	logic [DIV_W-1:0]     nq_q;
	logic [LH_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [LH_W:0]        rem_sh;
	logic [LH_W:0]        diff;
	logic                 fits;

	assign rem_sh = {rem_q, nq_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, denom};
	assign fits   = rem_sh >= {1'b0, denom};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= numer;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[LH_W-1:0] : rem_sh[LH_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = nq_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == DIV_CNT_W'(DIV_W))
		else $error("divider did not start");

endmodule

[design/wcm_dp.sv]
// ----------------------------------------------------------------------------
// wcm_dp: datapath of the wall column texture mapper
// Setup arithmetic, per-column state, row stepping and the output register.
// ----------------------------------------------------------------------------
module wcm_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wcm_pkg::wcm_cmd_t               cmd,
	output wcm_pkg::wcm_status_t            status,
	input  wcm_pkg::in_data_t               in_data,
	input  logic [wcm_pkg::TEXW_W-1:0]      tex_width,
	input  logic [wcm_pkg::HLOG_W-1:0]      hlog,
	input  logic [wcm_pkg::SCREEN_BITS-1:0] scr_width,
	input  logic [wcm_pkg::SCREEN_BITS-1:0] scr_height,
	input  logic                            out_ready,
	output logic                            out_valid,
	output wcm_pkg::out_data_t              out_data,
	output logic [wcm_pkg::SIDE_W-1:0]      out_side,
	output logic                            out_last
);
	import wcm_pkg::*;

	// setup pipeline
	logic [SIDE_W-1:0]      side_s1;
	logic                   mirror_s1;
	logic [FRAC_BITS-1:0]   player_lo_s1;
	logic [FRAC_BITS-1:0]   prod_hi_s1;
	logic [LH_W-1:0]        lh_s1;
	logic [SCREEN_BITS-1:0] row_first_s1;
	logic [SCREEN_BITS-1:0] row_end_s1;
	logic [SCREEN_BITS-1:0] column_s1;
	logic [FRAC_BITS-1:0]   frac_s2;
	logic [TEXW_W-1:0]      col_raw_s3;

	// column state
	logic                   active_q;
	logic [COL_W-1:0]       tex_column_q;
	logic [POS_W-1:0]       tex_pos_q;
	logic [DIV_W-1:0]       tex_step_q;
	logic [SCREEN_BITS-1:0] current_row_q;
	logic [SCREEN_BITS-1:0] end_row_q;
	logic [SCREEN_BITS-1:0] saved_column_q;
	logic [SIDE_W-1:0]      saved_side_q;

	// output register
	logic                   out_valid_q;
	logic [FI_W-1:0]        frame_index_q;
	logic [TEXEL_W-1:0]     texel_q;
	logic [SIDE_W-1:0]      out_side_q;
	logic                   out_last_q;

	logic                             is_ns;
	logic [COORD_W-1:0]               player_sel;
	logic [DIR_W-1:0]                 dir_sel;
	logic                             mirror;
	logic signed [COORD_W+DIR_W:0]    wall_prod;
	logic [FRAC_BITS+TEXW_W-1:0]      col_prod;
	logic [TEXW_W-1:0]                col_mir;
	logic [DIV_W-1:0]                 numer;
	logic [LH_W-1:0]                  denom;
	logic                             div_busy;
	logic [DIV_W-1:0]                 quot;
	logic [BASE_W-1:0]                base;
	logic signed [BASE_W+DIV_W:0]     pos_prod;
	logic [COL_W:0]                   hone;
	logic [COL_W-1:0]                 hmask;
	logic [COL_W-1:0]                 tex_row;
	logic [TEXEL_W-1:0]               texel;
	logic [FI_W-1:0]                  fi_prod;
	logic [SCREEN_BITS-1:0]           row_next;
	logic                             row_last;

	// setup: select by side, one wall product
	assign is_ns = (side_t'(in_data.side) == SIDE_NORTH) || (side_t'(in_data.side) == SIDE_SOUTH);
	assign player_sel = is_ns ? in_data.player_y : in_data.player_x;
	assign dir_sel    = is_ns ? in_data.ray_dir_y : in_data.ray_dir_x;
	assign mirror = is_ns ? (!in_data.ray_dir_x[DIR_W-1] && (|in_data.ray_dir_x))
	                      : in_data.ray_dir_y[DIR_W-1];
	assign wall_prod = $signed({1'b0, in_data.perp_dist}) * $signed(dir_sel);

	assign col_prod = frac_s2 * tex_width;
	assign col_mir  = tex_width - col_raw_s3 - 1'b1;

	// texture height in Q.FRAC_BITS: 1 << (hlog + FRAC_BITS)
	assign numer = (DIV_W'(1) << FRAC_BITS) << hlog;
	assign denom = (lh_s1 == '0) ? LH_W'(1) : lh_s1;

	assign base = BASE_W'(row_first_s1) - BASE_W'(scr_height >> 1) + BASE_W'(lh_s1 >> 1);
	assign pos_prod = $signed(base) * $signed({1'b0, quot});

	wcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.frac_en),
		.numer  (numer),
		.denom  (denom),
		.busy   (div_busy),
		.quot   (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			side_s1      <= in_data.side;
			mirror_s1    <= mirror;
			player_lo_s1 <= player_sel[FRAC_BITS-1:0];
			prod_hi_s1   <= wall_prod[2*FRAC_BITS-1:FRAC_BITS];
			lh_s1        <= in_data.line_height;
			row_first_s1 <= in_data.row_first;
			row_end_s1   <= in_data.row_end;
			column_s1    <= in_data.column;
		end
		if (cmd.frac_en) begin
			frac_s2 <= player_lo_s1 + prod_hi_s1;
		end
		if (cmd.col_en) begin
			col_raw_s3 <= col_prod[FRAC_BITS +: TEXW_W];
		end
	end

	// per-row arithmetic
	assign hone    = (COL_W+1)'(1) << hlog;
	assign hmask   = COL_W'(hone - 1'b1);
	assign tex_row = tex_pos_q[FRAC_BITS +: COL_W] & hmask;
	assign texel   = (TEXEL_W'(tex_row) << hlog) + TEXEL_W'(tex_column_q);
	assign fi_prod = {{(FI_W-SCREEN_BITS){1'b0}}, current_row_q}
	               * {{(FI_W-SCREEN_BITS){1'b0}}, scr_width};
	assign row_next = current_row_q + 1'b1;
	assign row_last = (row_next == '0) || (row_next >= end_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (cmd.pos_en) begin
			active_q <= row_first_s1 < row_end_s1;
		end else if (cmd.emit && row_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_en) begin
			tex_column_q   <= mirror_s1 ? col_mir[COL_W-1:0] : col_raw_s3[COL_W-1:0];
			tex_step_q     <= quot;
			tex_pos_q      <= POS_W'(pos_prod);
			current_row_q  <= row_first_s1;
			end_row_q      <= row_end_s1;
			saved_column_q <= column_s1;
			saved_side_q   <= side_s1;
		end else if (cmd.emit) begin
			tex_pos_q     <= tex_pos_q + POS_W'(tex_step_q);
			current_row_q <= row_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			frame_index_q <= fi_prod + FI_W'(saved_column_q);
			texel_q       <= texel;
			out_side_q    <= saved_side_q;
			out_last_q    <= row_last;
		end
	end

	assign status.active   = active_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign status.div_busy = div_busy;

	assign out_valid             = out_valid_q;
	assign out_data.pad          = '0;
	assign out_data.texel_offset = texel_q;
	assign out_data.frame_index  = frame_index_q;
	assign out_side              = out_side_q;
	assign out_last              = out_last_q;

	a_emit_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> active_q && (!out_valid_q || out_ready))
		else $error("row emitted without an armed column or a free output");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && row_last |=> !active_q)
		else $error("column still armed after its last row");

endmodule

[design/wcm_ctrl.sv]
// ----------------------------------------------------------------------------
// wcm_ctrl: controller of the wall column texture mapper
// Sequences column setup and gates row requests into the datapath.
// ----------------------------------------------------------------------------
module wcm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_command,
	output logic                 in_ready,
	input  wcm_pkg::wcm_status_t status,
	output wcm_pkg::wcm_cmd_t    cmd
);
	import wcm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FRAC,
		ST_COL,
		ST_DIV,
		ST_POS
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && status.out_free;
	assign accept   = in_valid && in_ready;

	assign cmd.capture = accept && (cmd_code_t'(in_command) == CMD_SETUP);
	assign cmd.emit    = accept && (cmd_code_t'(in_command) == CMD_ROW) && status.active;
	assign cmd.frac_en = state_q == ST_FRAC;
	assign cmd.col_en  = state_q == ST_COL;
	assign cmd.pos_en  = state_q == ST_POS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_FRAC;
					end
				end
				ST_FRAC: state_q <= ST_COL;
				ST_COL:  state_q <= ST_DIV;
				ST_DIV: begin
					if (!status.div_busy) begin
						state_q <= ST_POS;
					end
				end
				ST_POS:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_capture_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_FRAC)
		else $error("setup not sequenced");

	a_pos_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POS |-> !status.div_busy)
		else $error("position product started before step was ready");

endmodule

[design/wall_column_texture_mapper_top.sv]
// A row request (command 1) shows its result on the master side in the cycle after it
// is accepted; rows stream at one per cycle while the output is taken.
// Setup (command 0) holds s_axis_tready low after acceptance until the 27-step restoring
// divider has formed the texture step, one quotient bit per cycle, and the column is armed.
// Reset (arst_n low, asynchronous): the block idles with no column armed, the output
// register empty and the configuration registers at 64, 6, 640 and 480.
// ----------------------------------------------------------------------------
// wall_column_texture_mapper_top: raycast wall column to texture mapper
// Takes a column setup request, works out the texture column, step and start
// position, then turns each row request into a framebuffer index and a texel
// offset. Configuration lives behind an APB-style port.
// ----------------------------------------------------------------------------
module wall_column_texture_mapper_top (
	input  logic                              clk,
	input  logic                              arst_n,

	// APB-style configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wcm_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [wcm_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [wcm_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,

	// request stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata, low bit up: side, player_x, player_y, perp_dist, ray_dir_x,
	// ray_dir_y, line_height, row_first, row_end, column, zero pad
	input  logic [wcm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// tuser: command
	input  logic                              s_axis_tuser,

	// pixel request stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata, low bit up: frame_index, texel_offset, zero pad
	output logic [wcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// tuser: texture_select
	output logic [wcm_pkg::SIDE_W-1:0]        m_axis_tuser,
	output logic                              m_axis_tlast
);
	import wcm_pkg::*;

	logic [TEXW_W-1:0]      tex_width_q;
	logic [HLOG_W-1:0]      tex_hlog_q;
	logic [SCREEN_BITS-1:0] scr_width_q;
	logic [SCREEN_BITS-1:0] scr_height_q;
	logic                   cfg_write;
	reg_idx_t               cfg_idx;
	logic [HLOG_W-1:0]      hlog_eff;

	wcm_cmd_t    cmd;
	wcm_status_t status;
	out_data_t   out_data;

	// Configuration: write on the access phase, no wait states.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= TEXW_W'(64);
			tex_hlog_q   <= HLOG_W'(6);
			scr_width_q  <= SCREEN_BITS'(640);
			scr_height_q <= SCREEN_BITS'(480);
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_TEX_WIDTH:  tex_width_q  <= pwdata[TEXW_W-1:0];
				REG_TEX_HLOG2:  tex_hlog_q   <= pwdata[HLOG_W-1:0];
				REG_SCR_WIDTH:  scr_width_q  <= pwdata[SCREEN_BITS-1:0];
				REG_SCR_HEIGHT: scr_height_q <= pwdata[SCREEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back the stored value, zero extended.
	always_comb begin
		case (cfg_idx)
			REG_TEX_WIDTH:  prdata = APB_DATA_W'(tex_width_q);
			REG_TEX_HLOG2:  prdata = APB_DATA_W'(tex_hlog_q);
			REG_SCR_WIDTH:  prdata = APB_DATA_W'(scr_width_q);
			REG_SCR_HEIGHT: prdata = APB_DATA_W'(scr_height_q);
			default:        prdata = '0;
		endcase
	end

	// Texture heights above 1024 rows clamp to 1024.
	assign hlog_eff = clamp_hlog(tex_hlog_q);

	// Controller: owns the request handshake and the setup sequence.
	wcm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath: setup arithmetic, column state and output register.
	wcm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.in_data    (in_data_t'(s_axis_tdata)),
		.tex_width  (tex_width_q),
		.hlog       (hlog_eff),
		.scr_width  (scr_width_q),
		.scr_height (scr_height_q),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_data   (out_data),
		.out_side   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = out_data;

endmodule
